/* rtl/ffa_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by ffa_hdr_ram and first_fit_block_allocator.
package ffa_pkg;

  localparam int unsigned NumBlocksDef = 4096;
  localparam int unsigned HdrW         = 17;   // mark bit over 16-bit run length
  localparam int unsigned LenW         = 16;
  localparam int unsigned CntW         = 17;   // walk index, holds index plus a run length
  localparam int unsigned ByteW        = 20;
  localparam int unsigned ShiftW       = 4;
  localparam int unsigned WantW        = 19;
  localparam logic [ShiftW-1:0] ShiftReset = 4'd5;
  localparam logic [ShiftW-1:0] ShiftMin   = 4'd2;
  localparam logic [ShiftW-1:0] ShiftMax   = 4'd8;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_A_RD, S_A_CHK, S_A_WHDR,
    S_F_CHK,
    S_W_RD, S_W_CHK, S_W_NCHK, S_W_WN,
    S_E_RD, S_E_CHK, S_E_NCHK, S_E_WN,
    S_RESP
  } state_e;

endpackage

/* rtl/ffa_hdr_ram.sv */
// Single-port run header memory with registered read data.
// Depends on ffa_pkg for the header width.
module ffa_hdr_ram #(
  parameter int unsigned NumBlocks = ffa_pkg::NumBlocksDef
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic                          re_i,
  input  logic [$clog2(NumBlocks)-1:0]  addr_i,
  input  logic [ffa_pkg::HdrW-1:0]      wdata_i,
  output logic [ffa_pkg::HdrW-1:0]      rdata_o
);
  import ffa_pkg::*;

  logic [HdrW-1:0] mem [NumBlocks];
  logic [HdrW-1:0] rdata_q;

  // write or read one header per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/first_fit_block_allocator.sv */
// First-fit block allocator top level: request sequencer and result register.
// Depends on ffa_pkg and ffa_hdr_ram.
//
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries opcode_i (0 allocate,
//   1 free), request_bytes_i and free_offset_i. Result channel
//   (out_valid_o/out_ready_i) returns result_offset_o and status_o, one
//   result per request. The config channel (cfg_valid_i/cfg_ready_o) writes
//   block_shift_i; write it only while no request is in flight.
//   All run headers sit in one single-port memory with registered read data.
//   An allocate walks the runs until one fits; a free walks the runs
//   before the freed one and then merges the run after it. One request is
//   handled at a time.
//   After reset a clearing pass writes every header, during which no
//   request is taken (config writes still are).
//   A finished result waits in the output register while the next request
//   is already accepted; if the receiver stalls, the sequencer holds in its
//   result state until the register frees.
module first_fit_block_allocator #(
  parameter int unsigned NumBlocks = ffa_pkg::NumBlocksDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [ffa_pkg::ByteW-1:0]    request_bytes_i,
  input  logic [ffa_pkg::ByteW-1:0]    free_offset_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ffa_pkg::ByteW-1:0]    result_offset_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ffa_pkg::ShiftW-1:0]   block_shift_i
);
  import ffa_pkg::*;

  localparam int unsigned AddrW = $clog2(NumBlocks);
  localparam logic [CntW-1:0] NumC = CntW'(NumBlocks);
  localparam logic [LenW-1:0] FullLen = LenW'(NumBlocks - 1);

  state_e state_q, state_d;
  logic [ShiftW-1:0] shift_q;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [CntW-1:0]   i_q, i_d, id_q, id_d, nx_q, nx_d;
  logic [WantW-1:0]  want_q, want_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [1:0]        st_q, st_d;
  logic [ByteW-1:0]  off_q, off_d;
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  res_off_q, res_off_d;
  logic [1:0]        res_st_q, res_st_d;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_addr;
  logic [HdrW-1:0]   mem_wdata, mem_rdata;

  logic [ShiftW-1:0] eff_sh;
  logic              rd_mark;
  logic [LenW-1:0]   rd_len;
  logic [CntW-1:0]   rd_run;
  logic [ByteW:0]    round_sum;
  logic [ByteW-1:0]  free_id;
  logic [LenW-1:0]   sum_len;
  logic [CntW-1:0]   step_a, step_b;
  logic [24:0]       off_wide;

  ffa_hdr_ram #(.NumBlocks(NumBlocks)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // clamp block shift to the supported range
  always_comb begin
    if (shift_q < ShiftMin)      eff_sh = ShiftMin;
    else if (shift_q > ShiftMax) eff_sh = ShiftMax;
    else                         eff_sh = shift_q;
  end

  assign rd_mark   = mem_rdata[HdrW-1];
  assign rd_len    = mem_rdata[LenW-1:0];
  assign rd_run    = (rd_len == '0) ? CntW'(1) : CntW'(rd_len);
  assign round_sum = {1'b0, request_bytes_i} + ((ByteW+1)'(1) << eff_sh) - (ByteW+1)'(1);
  assign free_id   = free_offset_i >> eff_sh;
  assign sum_len   = len_q + rd_len;
  assign step_a    = i_q + rd_run;
  assign step_b    = nx_q + rd_run;
  assign off_wide  = {8'd0, i_q} << eff_sh;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign result_offset_o = res_off_q;
  assign status_o        = res_st_q;

  // sequencer: next state, header accesses and walk registers
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    i_d         = i_q;
    id_d        = id_q;
    nx_d        = nx_q;
    want_d      = want_q;
    len_d       = len_q;
    st_d        = st_q;
    off_d       = off_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_off_d   = res_off_q;
    res_st_d    = res_st_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = i_q[AddrW-1:0];
    mem_wdata   = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = (clr_q == AddrW'(1)) ? {1'b0, FullLen} : '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(NumBlocks - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          off_d = '0;
          i_d   = CntW'(1);
          if (opcode_i == OP_ALLOC) begin
            want_d = WantW'(round_sum >> eff_sh);
            if (request_bytes_i == '0) begin
              st_d    = ST_INVALID;
              state_d = S_RESP;
            end else begin
              state_d = S_A_RD;
            end
          end else begin
            id_d = CntW'(free_id);
            if (free_offset_i == '0 || free_id == '0 || free_id >= ByteW'(NumBlocks)) begin
              st_d    = ST_INVALID;
              state_d = S_RESP;
            end else begin
              mem_re   = 1'b1;
              mem_addr = free_id[AddrW-1:0];
              state_d  = S_F_CHK;
            end
          end
        end
      end
      // allocate: walk runs first fit
      S_A_RD: begin
        if (i_q >= NumC) begin
          st_d    = ST_NOFIT;
          state_d = S_RESP;
        end else begin
          mem_re  = 1'b1;
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (!rd_mark && WantW'(rd_len) >= want_q) begin
          if (WantW'(rd_len) > want_q) begin
            mem_we    = 1'b1;
            mem_addr  = AddrW'(i_q + CntW'(want_q));
            mem_wdata = {1'b0, rd_len - want_q[LenW-1:0]};
          end
          state_d = S_A_WHDR;
        end else begin
          i_d     = step_a;
          state_d = S_A_RD;
        end
      end
      S_A_WHDR: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, want_q[LenW-1:0]};
        st_d      = ST_DONE;
        off_d     = off_wide[ByteW-1:0];
        state_d   = S_RESP;
      end
      // free: check mark, clear it
      S_F_CHK: begin
        if (!rd_mark) begin
          st_d    = ST_INVALID;
          state_d = S_RESP;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = id_q[AddrW-1:0];
          mem_wdata = {1'b0, rd_len};
          state_d   = S_W_RD;
        end
      end
      // coalesce free runs lying before the freed run
      S_W_RD: begin
        if (i_q >= id_q) begin
          state_d = S_E_RD;
        end else begin
          mem_re  = 1'b1;
          state_d = S_W_CHK;
        end
      end
      S_W_CHK: begin
        len_d = rd_len;
        if (rd_mark) begin
          i_d     = step_a;
          state_d = S_W_RD;
        end else if (step_a >= NumC) begin
          state_d = S_E_RD;
        end else begin
          nx_d     = step_a;
          mem_re   = 1'b1;
          mem_addr = step_a[AddrW-1:0];
          state_d  = S_W_NCHK;
        end
      end
      S_W_NCHK: begin
        if (rd_mark) begin
          i_d     = step_b;
          state_d = S_W_RD;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {1'b0, sum_len};
          len_d     = sum_len;
          state_d   = S_W_WN;
        end
      end
      S_W_WN: begin
        mem_we   = 1'b1;
        mem_addr = nx_q[AddrW-1:0];
        if (i_q + CntW'(len_q) > id_q) id_d = i_q;
        if (len_q == '0) i_d = i_q + CntW'(1);
        state_d = S_W_RD;
      end
      // merge with a directly following free run
      S_E_RD: begin
        mem_re   = 1'b1;
        mem_addr = id_q[AddrW-1:0];
        state_d  = S_E_CHK;
      end
      S_E_CHK: begin
        len_d = rd_len;
        nx_d  = id_q + CntW'(rd_len);
        st_d  = ST_DONE;
        if (id_q + CntW'(rd_len) < NumC && rd_len != '0) begin
          mem_re   = 1'b1;
          mem_addr = AddrW'(id_q + CntW'(rd_len));
          state_d  = S_E_NCHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_E_NCHK: begin
        if (!rd_mark) begin
          mem_we    = 1'b1;
          mem_addr  = id_q[AddrW-1:0];
          mem_wdata = {1'b0, sum_len};
          state_d   = S_E_WN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_E_WN: begin
        mem_we   = 1'b1;
        mem_addr = nx_q[AddrW-1:0];
        state_d  = S_RESP;
      end
      // hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_off_d   = off_q;
          res_st_d    = st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      shift_q     <= ShiftReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) shift_q <= block_shift_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    id_q      <= id_d;
    nx_q      <= nx_d;
    want_q    <= want_d;
    len_q     <= len_d;
    st_q      <= st_d;
    off_q     <= off_d;
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
  end

  // no request taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o)
    else $error("request taken during clearing pass");

  // a header is only checked inside the pool
  a_walk_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_A_CHK |-> i_q < NumC)
    else $error("allocate walk beyond pool");

  // failed results carry a null offset
  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_st_q != ST_DONE |-> res_off_q == '0)
    else $error("failed result with non-null offset");

endmodule

/* dv/first_fit_block_allocator_tb.sv */
// Self-checking testbench for the first-fit block allocator.
// Depends on ffa_pkg and first_fit_block_allocator; carries its own header-table predictor.
module first_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int unsigned NBlk = NumBlocksDef;
  localparam int unsigned WatchLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = 1'b0;
  logic [ByteW-1:0] request_bytes_i = '0;
  logic [ByteW-1:0] free_offset_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ByteW-1:0] result_offset_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ShiftW-1:0] block_shift_i = '0;

  typedef struct packed {
    logic [ByteW-1:0] offset;
    status_e status;
  } alloc_result_t;

  // Predictor state: header table and block size register
  logic [HdrW-1:0] hdr_tbl [NBlk];
  logic [ShiftW-1:0] shift_reg;
  alloc_result_t pending_q [$];
  logic [ByteW-1:0] live_offs [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  first_fit_block_allocator u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .request_bytes_i,
    .free_offset_i, .out_valid_o, .out_ready_i, .result_offset_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .block_shift_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_shift();
    if (shift_reg < ShiftMin) return ShiftMin;
    if (shift_reg > ShiftMax) return ShiftMax;
    return shift_reg;
  endfunction

  function automatic int unsigned hdr_len(int unsigned idx);
    return hdr_tbl[idx][LenW-1:0];
  endfunction

  function automatic bit hdr_used(int unsigned idx);
    return hdr_tbl[idx][LenW];
  endfunction

  function automatic int unsigned step_len(int unsigned idx);
    return (hdr_len(idx) == 0) ? 1 : hdr_len(idx);
  endfunction

  function automatic void reset_table();
    foreach (hdr_tbl[k]) hdr_tbl[k] = '0;
    hdr_tbl[1] = HdrW'(NBlk - 1);
    shift_reg = ShiftReset;
  endfunction

  // First-fit walk from header 1; split the run when it is longer than needed
  function automatic alloc_result_t predict_alloc(logic [ByteW-1:0] bytes);
    alloc_result_t r;
    int unsigned sh, want, i, len;
    r.offset = '0;
    r.status = ST_NOFIT;
    if (bytes == 0) begin
      r.status = ST_INVALID;
      return r;
    end
    sh = eff_shift();
    want = (int'(bytes) + (1 << sh) - 1) >> sh;
    i = 1;
    while (i < NBlk) begin
      len = hdr_len(i);
      if (!hdr_used(i) && len >= want) begin
        if (len > want) hdr_tbl[i + want] = HdrW'(len - want);
        hdr_tbl[i] = {1'b1, LenW'(want)};
        r.offset = ByteW'(i << sh);
        r.status = ST_DONE;
        return r;
      end
      i += step_len(i);
    end
    return r;
  endfunction

  // Clear the mark, coalesce earlier free runs, then merge with the next run
  function automatic alloc_result_t predict_free(logic [ByteW-1:0] offs);
    alloc_result_t r;
    int unsigned id, i, nx, sum;
    r.offset = '0;
    r.status = ST_INVALID;
    if (offs == 0) return r;
    id = offs >> eff_shift();
    if (id == 0 || id >= NBlk) return r;
    if (!hdr_used(id)) return r;
    hdr_tbl[id][LenW] = 1'b0;
    i = 1;
    while (i < id) begin
      if (hdr_used(i)) begin
        i += step_len(i);
        continue;
      end
      nx = i + step_len(i);
      if (nx >= NBlk) break;
      if (hdr_used(nx)) begin
        i = nx + step_len(nx);
        continue;
      end
      sum = (hdr_len(i) + hdr_len(nx)) & 16'hFFFF;
      hdr_tbl[i] = HdrW'(sum);
      hdr_tbl[nx] = '0;
      if (i + sum > id) id = i;
      if (sum == 0) i += 1;
    end
    nx = id + hdr_len(id);
    if (nx < NBlk && nx != id && !hdr_used(nx)) begin
      hdr_tbl[id] = HdrW'((hdr_len(id) + hdr_len(nx)) & 16'hFFFF);
      hdr_tbl[nx] = '0;
    end
    r.status = ST_DONE;
    return r;
  endfunction

  // Send one item, predict its result on acceptance
  task automatic send_item(opcode_e op, logic [ByteW-1:0] bytes, logic [ByteW-1:0] offs);
    alloc_result_t r;
    do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    request_bytes_i <= bytes;
    free_offset_i <= offs;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    n_items++;
    if (op == OP_ALLOC) begin
      r = predict_alloc(bytes);
      if (r.status == ST_DONE) live_offs.push_back(r.offset);
    end else begin
      r = predict_free(offs);
      foreach (live_offs[k])
        if (r.status == ST_DONE && (live_offs[k] >> eff_shift()) == (offs >> eff_shift())) begin
          live_offs.delete(k);
          break;
        end
    end
    pending_q.push_back(r);
  endtask

  task automatic write_shift(logic [ShiftW-1:0] val);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    block_shift_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shift_reg = val;
  endtask

  // Free a random live run, sometimes at an unaligned offset
  task automatic free_some();
    int unsigned k;
    logic [ByteW-1:0] o;
    if (live_offs.size() == 0) return;
    k = $urandom_range(live_offs.size() - 1);
    o = live_offs[k];
    if ($urandom_range(3) == 0) o = o | ByteW'($urandom_range((1 << eff_shift()) - 1));
    send_item(OP_FREE, ByteW'($urandom), o);
  endtask

  task automatic test_directed();
    send_item(OP_ALLOC, 20'd0, 20'hFFFFF);
    send_item(OP_ALLOC, 20'd1, 20'd0);
    send_item(OP_ALLOC, 20'd32, 20'd0);
    send_item(OP_ALLOC, 20'd33, 20'd0);
    send_item(OP_ALLOC, 20'hFFFFF, 20'd0);
    send_item(OP_FREE, 20'hFFFFF, 20'd0);
    send_item(OP_FREE, 20'd0, 20'hFFFFF);
    send_item(OP_FREE, 20'd0, 20'd64);
    send_item(OP_FREE, 20'd0, 20'd64);
    send_item(OP_FREE, 20'd0, 20'd37);
    send_item(OP_FREE, 20'd0, 20'd100);
    send_item(OP_ALLOC, ByteW'((NBlk - 1) * 32), 20'd0);
    send_item(OP_FREE, 20'd0, 20'd32);
    send_item(OP_ALLOC, 20'd500, 20'd0);
    send_item(OP_ALLOC, 20'd4000, 20'd0);
    send_item(OP_ALLOC, 20'd64, 20'd0);
    send_item(OP_FREE, 20'd0, 20'd32);
    send_item(OP_FREE, 20'd0, 20'd1024);
  endtask

  // Mostly allocate/free traffic on live runs, some noise
  task automatic test_random(int count, int big_pct);
    int unsigned pick;
    logic [ByteW-1:0] sz;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        sz = ($urandom_range(99) < big_pct) ? ByteW'($urandom)
                                            : ByteW'($urandom_range(1, 3000));
        send_item(OP_ALLOC, sz, ByteW'($urandom));
      end else if (pick < 90 && live_offs.size() != 0) begin
        free_some();
      end else begin
        send_item(pick[0] ? OP_FREE : OP_ALLOC, ByteW'($urandom), ByteW'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(6, 0);
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
  endtask

  // Receiver: random stalls, hold-off, check each result against the oldest expected
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result offset=%h status=%0d", $time,
                 result_offset_o, status_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (result_offset_o !== want.offset) begin
          $display("%0t: result_offset expected %h actual %h", $time, want.offset,
                   result_offset_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
      end
    end
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles in which nothing moves
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("first_fit_block_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    int guard;
    reset_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 84;
    test_directed();
    test_random(80, 5);
    write_shift(4'd2);
    test_random(60, 5);
    write_shift(4'd8);
    send_idle_pct = 84;
    recv_idle_pct = 20;
    test_random(60, 5);
    write_shift(4'd0);
    test_random(40, 5);
    write_shift(4'd15);
    test_random(40, 5);
    write_shift(4'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(60, 5);
    test_backpressure();
    write_shift(4'd5);
    test_random(60, 5);
    guard = 0;
    while (pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests, %0d results checked, block sizes 4..256 bytes", n_items,
             n_results);
    $display("with allocate, free, coalescing, invalid and no-fit cases and a long stall.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("first_fit_block_allocator: match");
    end else begin
      $display("first_fit_block_allocator: mismatch");
    end
    $finish;
  end

endmodule
